// ----- rtl/core/thrb_pkg.sv -----
// Shared types and request codes for the tagged history ring buffer.
// Used by the record cell and the top level; depends on nothing else.
package thrb_pkg;

    localparam int ID_W   = 8;
    localparam int VAL_W  = 16;
    localparam int POS_W  = 5;
    localparam int REQ_W  = 3;
    localparam int MCNT_W = 6;

    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LIST  = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] value;
    } rec_t;

    typedef struct packed {
        logic add;
        logic rot;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/thrb_cell.sv -----
// One record cell of the history ring: holds a tagged record and loads it
// from its younger neighbor on an add or from its older neighbor on a rotate.
// Depends on thrb_pkg.
module thrb_cell import thrb_pkg::*; (
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  rec_t       shift_in,
    input  rec_t       rot_in,
    output rec_t       rec_out
);

    rec_t rec_reg;
    rec_t rec_next;

    always_comb begin
        rec_next = rec_reg;
        if (ctrl.add) begin
            rec_next = shift_in;
        end else if (ctrl.rot) begin
            rec_next = rot_in;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec_out = rec_reg;

endmodule

// ----- rtl/core/tagged_history_ring_buffer.sv -----
// Top level of the tagged history ring buffer: request decode, ring scan control
// and the result register. Depends on thrb_pkg and thrb_cell.
//
// The records live in a row of CAPACITY cells with the newest record in the first
// cell. An add shifts the row by one and, like a clear and a read beyond the stored
// count, goes to the result register without a rotation. Read, find and list
// requests rotate the whole row past the first cell, one record per cycle while no
// list result beat is held off by the result side, and the row is back in place
// when the rotation ends. A list with matches takes two rotations, the first to
// count the matches and the second to emit them; a list without a match takes one.
// One request is worked on at a time; the next beat is taken while the last result
// still waits in the output register.
module tagged_history_ring_buffer import thrb_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pulse_id [7:0], pulse_value [23:8], position [28:24], zero [31:29]
    input  logic [31:0] s_tdata,
    // req_type [2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_id [7:0], out_value [23:8], match_count [29:24], zero [31:30]
    output logic [31:0] m_tdata,
    // found [0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + POS_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    logic [REQ_W-1:0] req_reg, req_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SW-1:0]    step_reg, step_next;
    logic             pass_reg, pass_next;
    logic [CW-1:0]    hits_reg, hits_next;
    logic [CW-1:0]    emit_reg, emit_next;
    logic [ID_W-1:0]  res_id_reg, res_id_next;
    logic [VAL_W-1:0] res_val_reg, res_val_next;
    logic             res_found_reg, res_found_next;
    logic [CW-1:0]    res_cnt_reg, res_cnt_next;

    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [VAL_W-1:0]  out_val_reg, out_val_next;
    logic              out_found_reg, out_found_next;
    logic [MCNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic              out_last_reg, out_last_next;

    logic [REQ_W-1:0] in_req;
    logic [ID_W-1:0]  in_id;
    logic [VAL_W-1:0] in_val;
    logic [POS_W-1:0] in_pos;
    logic             s_accept;
    logic             out_free;
    logic             tap_active;
    logic             tap_match;
    logic             tap_at_pos;
    logic             step_last;
    logic             emit_stall;
    logic             advance;
    logic [XW-1:0]    target;
    rec_t             new_rec;
    rec_t             tap;
    cell_ctrl_t       cell_ctrl;
    rec_t             cell_q [CAPACITY];

    assign in_req = s_tuser;
    assign in_id  = s_tdata[7:0];
    assign in_val = s_tdata[23:8];
    assign in_pos = s_tdata[28:24];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign new_rec.id    = in_id;
    assign new_rec.value = in_val;
    assign tap           = cell_q[0];

    assign tap_active = (CW'(step_reg) < cnt_reg);
    assign tap_match  = tap_active && (tap.id == id_reg);
    assign target     = XW'(cnt_reg) - XW'(pos_reg) - XW'(1);
    assign tap_at_pos = (XW'(step_reg) == target);
    assign step_last  = (step_reg == SW'(CAPACITY - 1));
    assign emit_stall = (req_reg == REQ_LIST) && pass_reg && tap_match && !out_free;
    assign advance    = (state_reg == ST_SCAN) && !emit_stall;

    assign cell_ctrl.add = s_accept && (in_req == REQ_ADD);
    assign cell_ctrl.rot = advance;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        rec_t shift_src;
        rec_t rot_src;
        if (g == 0) begin : g_head
            assign shift_src = new_rec;
        end else begin : g_body
            assign shift_src = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign rot_src = cell_q[0];
        end else begin : g_inner
            assign rot_src = cell_q[g+1];
        end
        thrb_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .shift_in (shift_src),
            .rot_in   (rot_src),
            .rec_out  (cell_q[g])
        );
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        id_next        = id_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        pass_next      = pass_reg;
        hits_next      = hits_reg;
        emit_next      = emit_reg;
        res_id_next    = res_id_reg;
        res_val_next   = res_val_reg;
        res_found_next = res_found_reg;
        res_cnt_next   = res_cnt_reg;
        out_id_next    = out_id_reg;
        out_val_next   = out_val_reg;
        out_found_next = out_found_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next       = in_req;
                    id_next        = in_id;
                    pos_next       = in_pos;
                    step_next      = '0;
                    pass_next      = 1'b0;
                    hits_next      = '0;
                    emit_next      = '0;
                    res_id_next    = '0;
                    res_val_next   = '0;
                    res_found_next = 1'b0;
                    res_cnt_next   = cnt_reg;
                    unique case (in_req)
                        REQ_ADD: begin
                            if (cnt_reg != CW'(CAPACITY)) begin
                                cnt_next = cnt_reg + CW'(1);
                            end
                            res_cnt_next = cnt_next;
                            state_next   = ST_RESP;
                        end
                        REQ_CLEAR: begin
                            cnt_next     = '0;
                            res_cnt_next = '0;
                            state_next   = ST_RESP;
                        end
                        REQ_READ: begin
                            if (XW'(in_pos) >= XW'(cnt_reg)) begin
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_FIND: begin
                            state_next = ST_SCAN;
                        end
                        REQ_LIST: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    step_next = step_last ? '0 : step_reg + SW'(1);
                    unique case (req_reg)
                        REQ_READ: begin
                            if (tap_at_pos) begin
                                res_id_next    = tap.id;
                                res_val_next   = tap.value;
                                res_found_next = 1'b1;
                            end
                        end
                        REQ_FIND: begin
                            if (tap_match && !res_found_reg) begin
                                res_id_next    = tap.id;
                                res_val_next   = tap.value;
                                res_found_next = 1'b1;
                            end
                        end
                        REQ_LIST: begin
                            if (tap_match) begin
                                if (!pass_reg) begin
                                    hits_next = hits_reg + CW'(1);
                                end else begin
                                    m_valid_next   = 1'b1;
                                    out_id_next    = id_reg;
                                    out_val_next   = tap.value;
                                    out_found_next = 1'b1;
                                    out_cnt_next   = MCNT_W'(hits_reg);
                                    out_last_next  = ((emit_reg + CW'(1)) == hits_reg);
                                    emit_next      = emit_reg + CW'(1);
                                end
                            end
                        end
                        default: begin
                            res_found_next = res_found_reg;
                        end
                    endcase
                    if (step_last) begin
                        if (req_reg == REQ_LIST) begin
                            if (pass_reg) begin
                                state_next = ST_IDLE;
                            end else if (hits_next == '0) begin
                                res_id_next    = id_reg;
                                res_val_next   = '0;
                                res_found_next = 1'b0;
                                res_cnt_next   = '0;
                                state_next     = ST_RESP;
                            end else begin
                                pass_next = 1'b1;
                            end
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_id_next    = res_id_reg;
                    out_val_next   = res_val_reg;
                    out_found_next = res_found_reg;
                    out_cnt_next   = MCNT_W'(res_cnt_reg);
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        id_reg        <= id_next;
        pos_reg       <= pos_next;
        step_reg      <= step_next;
        pass_reg      <= pass_next;
        hits_reg      <= hits_next;
        emit_reg      <= emit_next;
        res_id_reg    <= res_id_next;
        res_val_reg   <= res_val_next;
        res_found_reg <= res_found_next;
        res_cnt_reg   <= res_cnt_next;
        out_id_reg    <= out_id_next;
        out_val_reg   <= out_val_next;
        out_found_reg <= out_found_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_cnt_reg, out_val_reg, out_id_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- tb/tagged_history_ring_buffer_tb.sv -----
// Self-checking testbench for the tagged history ring buffer: directed and random
// requests go through a stream driver, and every result beat is checked against a
// behavioral ring model kept inside this file. Depends on thrb_pkg and the RTL.
module tagged_history_ring_buffer_tb;
    import thrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 32;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 3 * CAP;
    localparam int CALM_FROM = 800;
    localparam int CALM_TO = 1600;
    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [ID_W-1:0] BURST_TAG = 8'h3C;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
    } pulse_req_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [VAL_W-1:0]  value;
        logic              found;
        logic [MCNT_W-1:0] tally;
        logic              last;
    } pulse_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    pulse_req_t   req_backlog[$];
    pulse_reply_t replies_due[$];
    pulse_req_t   on_bus;
    int           err_count = 0;
    int           cyc = 0;

    rec_t       ring_mem[CAP];
    int         ring_wptr = 0;
    logic       ring_full = 1'b0;

    tagged_history_ring_buffer #(.CAPACITY(CAP)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    function automatic bit calm();
        return cyc >= CALM_FROM && cyc < CALM_TO;
    endfunction

    function automatic int ring_held();
        return ring_full ? CAP : ring_wptr;
    endfunction

    function automatic int ring_slot(input int age);
        return ring_full ? (ring_wptr + age) % CAP : age;
    endfunction

    function automatic void await_reply(input logic [ID_W-1:0] id,
                                        input logic [VAL_W-1:0] value,
                                        input logic found, input int tally,
                                        input logic last);
        pulse_reply_t r;
        r.id = id;
        r.value = value;
        r.found = found;
        r.tally = tally[MCNT_W-1:0];
        r.last = last;
        replies_due.push_back(r);
    endfunction

    // Updates the ring model for one accepted request and queues its result beats.
    function automatic void forecast_replies(input pulse_req_t q);
        int held;
        int hits;
        int k;
        bit hit;
        rec_t e;
        held = ring_held();
        case (q.kind)
            REQ_ADD: begin
                ring_mem[ring_wptr] = {q.id, q.value};
                ring_wptr++;
                if (ring_wptr >= CAP) begin
                    ring_wptr = 0;
                    ring_full = 1'b1;
                end
                await_reply('0, '0, 1'b0, ring_held(), 1'b1);
            end
            REQ_CLEAR: begin
                ring_wptr = 0;
                ring_full = 1'b0;
                await_reply('0, '0, 1'b0, 0, 1'b1);
            end
            REQ_READ: begin
                if (int'(q.pos) >= held) begin
                    await_reply('0, '0, 1'b0, held, 1'b1);
                end else begin
                    e = ring_mem[ring_slot(int'(q.pos))];
                    await_reply(e.id, e.value, 1'b1, held, 1'b1);
                end
            end
            REQ_FIND: begin
                hit = 1'b0;
                for (int i = held - 1; i >= 0 && !hit; i--) begin
                    e = ring_mem[ring_slot(i)];
                    if (e.id == q.id) begin
                        await_reply(q.id, e.value, 1'b1, held, 1'b1);
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    await_reply('0, '0, 1'b0, held, 1'b1);
                end
            end
            REQ_LIST: begin
                hits = 0;
                for (int i = 0; i < held; i++) begin
                    if (ring_mem[ring_slot(i)].id == q.id) hits++;
                end
                if (hits == 0) begin
                    await_reply(q.id, '0, 1'b0, 0, 1'b1);
                end else begin
                    k = 0;
                    for (int i = held - 1; i >= 0; i--) begin
                        e = ring_mem[ring_slot(i)];
                        if (e.id == q.id) begin
                            k++;
                            await_reply(q.id, e.value, 1'b1, hits, k == hits);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic [VAL_W-1:0] value, input logic [POS_W-1:0] pos);
        pulse_req_t q;
        q.kind = kind;
        q.id = id;
        q.value = value;
        q.pos = pos;
        req_backlog.push_back(q);
    endtask

    // Mostly adds and lookups over a narrow tag set so that searches hit often.
    task automatic queue_mixed(input int n);
        int done;
        int roll;
        logic [ID_W-1:0] tag;
        logic [POS_W-1:0] pos;
        done = 0;
        while (done < n) begin
            roll = $urandom_range(99);
            tag = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
            pos = ($urandom_range(1) == 0) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
            if (roll < 48) begin
                queue_req(REQ_ADD, tag, 16'($urandom), pos);
            end else if (roll < 62) begin
                queue_req(REQ_READ, tag, 16'($urandom), pos);
            end else if (roll < 76) begin
                queue_req(REQ_FIND, tag, 16'($urandom), pos);
            end else if (roll < 90) begin
                queue_req(REQ_LIST, tag, 16'($urandom), pos);
            end else if (roll < 94) begin
                queue_req(REQ_CLEAR, tag, 16'($urandom), pos);
            end else begin
                queue_req(REQ_UNUSED_FIRST + 3'($urandom_range(2)), tag, 16'($urandom), pos);
                continue;
            end
            done++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) forecast_replies(on_bus);
            if (!s_tvalid || s_tready) begin
                if (req_backlog.size() != 0 && (calm() || $urandom_range(99) >= 27)) begin
                    on_bus = req_backlog.pop_front();
                    s_tdata <= {3'b000, on_bus.pos, on_bus.value, on_bus.id};
                    s_tuser <= on_bus.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        pulse_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result beat, data %h", m_tdata));
                end else begin
                    want = replies_due.pop_front();
                    if (m_tdata[7:0] !== want.id)
                        flag_mismatch($sformatf("out_id %h, want %h", m_tdata[7:0], want.id));
                    if (m_tdata[23:8] !== want.value)
                        flag_mismatch($sformatf("out_value %h, want %h",
                                                m_tdata[23:8], want.value));
                    if (m_tuser[0] !== want.found)
                        flag_mismatch($sformatf("found %b, want %b", m_tuser[0], want.found));
                    if (m_tdata[29:24] !== want.tally)
                        flag_mismatch($sformatf("match_count %0d, want %0d",
                                                m_tdata[29:24], want.tally));
                    if (m_tlast !== want.last)
                        flag_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                end
            end
            m_tready <= calm() || $urandom_range(99) >= 27;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tagged_history_ring_buffer verification failed");
        $finish;
    end

    initial begin
        queue_req(REQ_READ, 8'h00, 16'h0000, 5'd0);
        queue_req(REQ_FIND, 8'h12, 16'h0000, 5'd0);
        queue_req(REQ_LIST, 8'h12, 16'h0000, 5'd0);
        queue_req(REQ_ADD, 8'h00, 16'h8000, 5'd0);
        queue_req(REQ_ADD, 8'hFF, 16'h7FFF, 5'd31);
        queue_req(REQ_ADD, 8'h12, 16'hFFFF, 5'd0);
        queue_req(REQ_ADD, 8'h12, 16'h0001, 5'd0);
        queue_req(REQ_READ, 8'h00, 16'h0000, 5'd0);
        queue_req(REQ_READ, 8'h00, 16'h0000, 5'd3);
        queue_req(REQ_READ, 8'h00, 16'h0000, 5'd4);
        queue_req(REQ_READ, 8'hFF, 16'hFFFF, 5'd31);
        queue_req(REQ_FIND, 8'h12, 16'h0000, 5'd0);
        queue_req(REQ_FIND, 8'h77, 16'h0000, 5'd0);
        queue_req(REQ_LIST, 8'h12, 16'h0000, 5'd0);
        queue_req(REQ_LIST, 8'hFF, 16'h0000, 5'd0);
        queue_req(REQ_LIST, 8'h34, 16'h0000, 5'd0);
        queue_req(REQ_UNUSED_FIRST, 8'h12, 16'h1234, 5'd1);
        queue_req(REQ_UNUSED_FIRST + 3'd1, 8'hFF, 16'hFFFF, 5'd31);
        queue_req(REQ_UNUSED_FIRST + 3'd2, 8'h00, 16'h8000, 5'd0);
        queue_req(REQ_CLEAR, 8'hFF, 16'hFFFF, 5'd31);
        queue_req(REQ_READ, 8'h00, 16'h0000, 5'd0);
        queue_req(REQ_ADD, 8'hA5, 16'h5A5A, 5'd0);
        queue_req(REQ_FIND, 8'hA5, 16'h0000, 5'd0);

        queue_mixed(30);

        // Wrap the ring with one tag so that a list returns every stored record.
        queue_req(REQ_CLEAR, 8'h00, 16'($urandom), 5'($urandom));
        for (int i = 0; i < CAP + 3; i++)
            queue_req(REQ_ADD, BURST_TAG, 16'($urandom), 5'($urandom));
        queue_req(REQ_LIST, BURST_TAG, 16'($urandom), 5'($urandom));
        queue_req(REQ_FIND, BURST_TAG, 16'($urandom), 5'($urandom));
        queue_req(REQ_READ, 8'h00, 16'($urandom), 5'd0);
        queue_req(REQ_READ, 8'h00, 16'($urandom), 5'd31);
        queue_req(REQ_ADD, 8'h05, 16'($urandom), 5'($urandom));
        queue_req(REQ_LIST, BURST_TAG, 16'($urandom), 5'($urandom));
        queue_req(REQ_FIND, 8'h05, 16'($urandom), 5'($urandom));

        queue_mixed(30);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (req_backlog.size() != 0 || s_tvalid) @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tagged_history_ring_buffer verification clean");
        end else begin
            $display("tagged_history_ring_buffer verification failed");
        end
        $finish;
    end

endmodule
